@@ rtl/pts_pkg.sv @@
// shared types, constants and codes of the photon transport heating block
`default_nettype none
package pts_pkg;

  localparam int SHELL_COUNT = 128;
  localparam int SHELL_BITS  = $clog2(SHELL_COUNT);
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int LOG_STEPS   = 24;
  localparam int ROOT_STEPS  = 32;
  localparam int HEAT_W      = 64;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  localparam logic [15:0] ALBEDO_RESET = 16'd59578;
  localparam logic [31:0] SPFP_RESET   = 32'd595782;
  localparam logic [31:0] WTHR_RESET   = 32'd4294967;
  localparam logic [31:0] STHR_RESET   = 32'd429496730;
  localparam logic [31:0] TARGET_RESET = 32'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALBEDO = 3'd0,
    REG_SPFP   = 3'd1,
    REG_WTHR   = 3'd2,
    REG_STHR   = 3'd3,
    REG_TARGET = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_MOVE = 2'd0,
    PH_XI1  = 2'd1,
    PH_XI2  = 2'd2,
    PH_ROUL = 2'd3
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LOG_INIT, S_LOG_NORM, S_LOG_SQ, S_LOG_SQW, S_LOG_LN, S_LOG_LNW,
    S_MOVE, S_MOVEW, S_SQ, S_SQW, S_ROOT, S_SHELL, S_SHELLW, S_DEP, S_DEPW,
    S_DSQ, S_DSQW, S_ACC, S_WT, S_WTW, S_DIR1, S_DIR2, S_DIR3, S_DV, S_DW,
    S_DWW, S_ROUL, S_ROULW, S_READ, S_EMIT
  } back_state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] rand_value;
    logic [6:0]  shell_index;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [31:0]       photons_finished;
    logic              run_done;
    logic [HEAT_W-1:0] heat_value;
    logic [HEAT_W-1:0] heat_square_value;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
    logic [6:0]  idx;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t entry;
  } q_link_t;

  typedef struct packed {
    logic [15:0] albedo;
    logic [31:0] spfp;
    logic [31:0] wthr;
    logic [31:0] sthr;
    logic [31:0] target;
  } cfg_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pts_ram.sv @@
// generic single-write, single-read ram with registered read
`default_nettype none
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/pts_front.sv @@
// input side: accepts items, tags their operation and queues them for the engine
`default_nettype none
module pts_front import pts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  output q_link_t       link,
  input  wire logic     take
);

  q_item_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;
  logic                   do_push;
  logic                   do_take;
  q_item_t                tagged_item;

  function automatic logic [QUEUE_AW-1:0] bump(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_take = take && (count != '0);

  always_comb begin
    tagged_item.op    = item.kind ? OP_READ : OP_DRAW;
    tagged_item.value = item.rand_value;
    tagged_item.idx   = item.shell_index;
  end

  assign link.valid = (count != '0);
  assign link.entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= tagged_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_take) rd_ptr <= bump(rd_ptr);
      if (do_push && !do_take) count <= count + 1'b1;
      else if (!do_push && do_take) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/pts_back.sv @@
// engine: photon step sequencer with shared multiplier, root and log units
`default_nettype none
module pts_back import pts_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire q_link_t link,
  output logic         take,
  output logic         empty,
  input  wire logic    pop,
  output out_item_t    result
);

  back_state_e state, state_next;
  phase_e      phase;
  logic [31:0] pos [3];
  logic [31:0] dir [3];
  logic [31:0] weight;
  logic [31:0] pending;
  logic [31:0] count;
  q_item_t     cur;
  logic [31:0] t;
  logic [63:0] acc;
  logic [4:0]  cnt;
  logic [31:0] m;
  logic [4:0]  k;
  logic [23:0] frac;
  logic [63:0] sq_n, sq_res, sq_bit;
  logic        ret_dir;
  logic [SHELL_BITS-1:0] shell;
  logic [33:0] dep;
  logic [32:0] dsq;
  logic        old_valid;
  logic [1:0]  ax;
  logic        is_read;
  logic        res_valid;
  logic [SHELL_COUNT-1:0] valid;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        ram_wr, ram_rd;
  logic [SHELL_BITS-1:0] ram_rd_addr;
  logic [2*HEAT_W-1:0]   ram_rd_data, ram_wr_data;

  logic        done;
  logic        emit;
  logic [31:0] x1, x2, m1, m2;
  logic [29:0] neg_log;
  logic [32:0] sqp;
  logic [35:0] pe, de, np;
  logic [31:0] sat_pos;
  logic [63:0] root_try;
  logic [63:0] sh_raw;
  logic [SHELL_BITS-1:0] shell_c;
  logic [63:0] s_sum;
  logic [63:0] old_h, old_q;
  logic [64:0] add_h, add_q;
  logic [63:0] new_h, new_q;
  logic [31:0] v_mag, w_mag;

  assign done = (count >= cfg.target);
  assign emit = (state == S_EMIT) && (!res_valid || pop);
  assign empty = !res_valid;

  assign x1 = {1'b0, pending[31:1]} - ONE_Q30;
  assign x2 = {1'b0, cur.value[31:1]} - ONE_Q30;
  assign m1 = abs32(x1);
  assign m2 = abs32(x2);
  assign neg_log = 30'(32'd32 << 24) - {1'b0, k, frac};
  assign sqp = mul_p[63:31];
  assign pe = {{4{pos[ax][31]}}, pos[ax]};
  assign de = {2'b0, mul_p[63:30]};
  assign np = dir[ax][31] ? (pe - de) : (pe + de);
  assign root_try = sq_res + sq_bit;
  assign sh_raw = {32'b0, mul_p[63:32]};
  assign shell_c = (sh_raw > 64'(SHELL_COUNT - 1)) ? SHELL_BITS'(SHELL_COUNT - 1)
                                                   : sh_raw[SHELL_BITS-1:0];
  assign s_sum = acc + mul_p;
  assign old_h = old_valid ? ram_rd_data[2*HEAT_W-1:HEAT_W] : '0;
  assign old_q = old_valid ? ram_rd_data[HEAT_W-1:0] : '0;
  assign add_h = {1'b0, old_h} + {31'b0, dep};
  assign add_q = {1'b0, old_q} + {32'b0, dsq};
  assign new_h = add_h[64] ? '1 : add_h[63:0];
  assign new_q = add_q[64] ? '1 : add_q[63:0];
  assign ram_wr_data = {new_h, new_q};
  assign v_mag = mul_p[60:29];
  assign w_mag = mul_p[60:29];

  always_comb begin
    if ($signed(np) > $signed(36'sh0_7FFF_FFFF)) sat_pos = 32'h7FFF_FFFF;
    else if ($signed(np) < -$signed(36'sh0_8000_0000)) sat_pos = 32'h8000_0000;
    else sat_pos = np[31:0];
  end

  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
  end

  pts_ram #(.WIDTH(2 * HEAT_W), .DEPTH(SHELL_COUNT)) u_heat (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (shell),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (link.valid) begin
          if (link.entry.op == OP_READ) state_next = S_READ;
          else if (done) state_next = S_IDLE;
          else begin
            case (phase)
              PH_MOVE: state_next = S_LOG_INIT;
              PH_XI1:  state_next = S_IDLE;
              PH_XI2:  state_next = S_DIR1;
              PH_ROUL: state_next = S_ROUL;
              default: state_next = S_IDLE;
            endcase
          end
        end
      end
      S_LOG_INIT: state_next = (cur.value == '0) ? S_MOVE : S_LOG_NORM;
      S_LOG_NORM: state_next = m[31] ? S_LOG_SQ : S_LOG_NORM;
      S_LOG_SQ:   state_next = S_LOG_SQW;
      S_LOG_SQW:  state_next = (cnt == 5'(LOG_STEPS - 1)) ? S_LOG_LN : S_LOG_SQ;
      S_LOG_LN:   state_next = S_LOG_LNW;
      S_LOG_LNW:  state_next = S_MOVE;
      S_MOVE:     state_next = S_MOVEW;
      S_MOVEW:    state_next = (ax == 2'd2) ? S_SQ : S_MOVE;
      S_SQ:       state_next = S_SQW;
      S_SQW:      state_next = (ax == 2'd2) ? S_ROOT : S_SQ;
      S_ROOT: begin
        if (cnt == 5'(ROOT_STEPS - 1)) state_next = ret_dir ? S_DV : S_SHELL;
      end
      S_SHELL:    state_next = S_SHELLW;
      S_SHELLW:   state_next = S_DEP;
      S_DEP:      state_next = S_DEPW;
      S_DEPW:     state_next = S_DSQ;
      S_DSQ:      state_next = S_DSQW;
      S_DSQW:     state_next = S_ACC;
      S_ACC:      state_next = S_WT;
      S_WT:       state_next = S_WTW;
      S_WTW:      state_next = S_IDLE;
      S_DIR1:     state_next = S_DIR2;
      S_DIR2:     state_next = S_DIR3;
      S_DIR3: begin
        if (s_sum == '0 || s_sum > (64'd1 << 60)) state_next = S_IDLE;
        else state_next = S_ROOT;
      end
      S_DV:       state_next = S_DW;
      S_DW:       state_next = S_DWW;
      S_DWW:      state_next = S_IDLE;
      S_ROUL:     state_next = (cur.value > cfg.sthr) ? S_EMIT : S_ROULW;
      S_ROULW:    state_next = S_IDLE;
      S_READ:     state_next = S_EMIT;
      S_EMIT:     state_next = emit ? S_IDLE : S_EMIT;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    ram_wr      = 1'b0;
    ram_rd      = 1'b0;
    ram_rd_addr = shell_c;
    take        = (state == S_IDLE) && link.valid;
    case (state)
      S_LOG_SQ: begin mul_a = m; mul_b = m; end
      S_LOG_LN: begin mul_a = {2'b0, neg_log}; mul_b = LN2_Q32; end
      S_MOVE:   begin mul_a = t; mul_b = abs32(dir[ax]); end
      S_SQ:     begin mul_a = abs32(pos[ax]); mul_b = abs32(pos[ax]); end
      S_SHELL:  begin mul_a = sq_res[31:0]; mul_b = cfg.spfp; end
      S_SHELLW: ram_rd = 1'b1;
      S_DEP:    begin mul_a = weight; mul_b = 32'(17'h1_0000 - {1'b0, cfg.albedo}); end
      S_DSQ:    begin mul_a = dep[31:0]; mul_b = dep[31:0]; end
      S_ACC:    ram_wr = 1'b1;
      S_WT:     begin mul_a = weight; mul_b = {16'b0, cfg.albedo}; end
      S_DIR1:   begin mul_a = m1; mul_b = m1; end
      S_DIR2:   begin mul_a = m2; mul_b = m2; end
      S_DV:     begin mul_a = m1; mul_b = sq_res[31:0]; end
      S_DW:     begin mul_a = m2; mul_b = sq_res[31:0]; end
      S_ROUL:   begin mul_a = weight; mul_b = 32'd10; end
      S_READ: begin
        ram_rd      = 1'b1;
        ram_rd_addr = cur.idx[SHELL_BITS-1:0];
      end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_MOVE;
      pos[0]    <= '0;
      pos[1]    <= '0;
      pos[2]    <= '0;
      dir[0]    <= '0;
      dir[1]    <= '0;
      dir[2]    <= ONE_Q30;
      weight    <= ONE_Q31;
      pending   <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      valid     <= '0;
    end else begin
      state <= state_next;
      if (emit) res_valid <= 1'b1;
      else if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (link.valid) begin
            cur <= link.entry;
            if (link.entry.op == OP_DRAW && !done && phase == PH_XI1) begin
              pending <= link.entry.value;
              phase   <= PH_XI2;
            end
          end
        end
        S_LOG_INIT: begin
          ax <= 2'd0;
          if (cur.value == '0) t <= '1;
          else begin
            m <= cur.value;
            k <= 5'd31;
          end
        end
        S_LOG_NORM: begin
          if (!m[31]) begin
            m <= m << 1;
            k <= k - 5'd1;
          end else begin
            cnt  <= '0;
            frac <= '0;
          end
        end
        S_LOG_SQW: begin
          if (sqp[32]) begin
            frac <= frac | (24'd1 << (5'(LOG_STEPS - 1) - cnt));
            m    <= sqp[32:1];
          end else begin
            m <= sqp[31:0];
          end
          cnt <= cnt + 5'd1;
        end
        S_LOG_LNW: begin
          t  <= 32'((mul_p + (64'd1 << 39)) >> 40);
          ax <= 2'd0;
        end
        S_MOVEW: begin
          pos[ax] <= sat_pos;
          if (ax == 2'd2) begin
            ax  <= 2'd0;
            acc <= '0;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        S_SQW: begin
          acc <= s_sum;
          ax  <= ax + 2'd1;
          if (ax == 2'd2) begin
            sq_n    <= s_sum;
            sq_res  <= '0;
            sq_bit  <= 64'd1 << 62;
            cnt     <= '0;
            ret_dir <= 1'b0;
          end
        end
        S_ROOT: begin
          if (sq_n >= root_try) begin
            sq_n   <= sq_n - root_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 5'd1;
        end
        S_SHELLW: begin
          shell     <= shell_c;
          old_valid <= valid[shell_c];
        end
        S_DEPW: dep <= mul_p[48:15];
        S_DSQW: dsq <= (dep[33:32] != 2'b0) ? 33'h1_0000_0000 : {1'b0, mul_p[63:32]};
        S_ACC:  valid[shell] <= 1'b1;
        S_WTW: begin
          weight <= mul_p[47:16];
          phase  <= PH_XI1;
        end
        S_DIR2: acc <= mul_p;
        S_DIR3: begin
          if (s_sum == '0 || s_sum > (64'd1 << 60)) begin
            phase <= PH_XI1;
          end else begin
            dir[0]  <= s_sum[60:29] - ONE_Q30;
            sq_n    <= (64'd1 << 60) - s_sum;
            sq_res  <= '0;
            sq_bit  <= 64'd1 << 62;
            cnt     <= '0;
            ret_dir <= 1'b1;
          end
        end
        S_DW:  dir[1] <= x1[31] ? (~v_mag + 32'd1) : v_mag;
        S_DWW: begin
          dir[2] <= x2[31] ? (~w_mag + 32'd1) : w_mag;
          phase  <= ({weight, 1'b0} < {1'b0, cfg.wthr}) ? PH_ROUL : PH_MOVE;
        end
        S_ROUL: begin
          if (cur.value > cfg.sthr) begin
            if (count != '1) count <= count + 32'd1;
            pos[0]  <= '0;
            pos[1]  <= '0;
            pos[2]  <= '0;
            dir[0]  <= '0;
            dir[1]  <= '0;
            dir[2]  <= ONE_Q30;
            weight  <= ONE_Q31;
            phase   <= PH_MOVE;
            is_read <= 1'b0;
          end
        end
        S_ROULW: begin
          weight <= (mul_p[63:32] != '0) ? '1 : mul_p[31:0];
          phase  <= PH_MOVE;
        end
        S_READ: begin
          is_read   <= 1'b1;
          old_valid <= valid[cur.idx[SHELL_BITS-1:0]];
        end
        default: begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.result_kind       <= is_read;
      result.photons_finished  <= count;
      result.run_done          <= done;
      result.heat_value        <= is_read ? old_h : '0;
      result.heat_square_value <= is_read ? old_q : '0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/photon_transport_shell_heating_unit.sv @@
// top level of the photon transport shell heating engine
//
//  channel  | handshake        | payload
//  ---------+------------------+----------------------------------------
//  input    | push / full      | item   (kind, rand_value, shell_index)
//  result   | pop / empty      | result (kind, count, done, heat sums)
//  config   | wr_en            | wr_index, wr_data
//
// a step draw runs the leading-one shift, the 24 log squarings on the shared multiplier and the
// radius root; a zero draw skips the log and takes the saturated step
// a second direction draw runs the 32-step root unit, or skips the root when rejected
// first draws are only stored; a roulette end and reads also wait for the result slot
// reset clears the state and the heat store valid bits
// a two-item queue lets input keep arriving while the engine works or the result waits
`default_nettype none
module photon_transport_shell_heating_unit import pts_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire in_item_t             item,
  output logic                      empty,
  input  wire logic                 pop,
  output out_item_t                 result,
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [31:0]          wr_data
);

  cfg_t    cfg;
  q_link_t link;
  logic    take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.albedo <= ALBEDO_RESET;
      cfg.spfp   <= SPFP_RESET;
      cfg.wthr   <= WTHR_RESET;
      cfg.sthr   <= STHR_RESET;
      cfg.target <= TARGET_RESET;
    end else if (wr_en) begin
      case (cfg_reg_e'(wr_index))
        REG_ALBEDO: cfg.albedo <= wr_data[15:0];
        REG_SPFP:   cfg.spfp   <= wr_data;
        REG_WTHR:   cfg.wthr   <= wr_data;
        REG_STHR:   cfg.sthr   <= wr_data;
        REG_TARGET: cfg.target <= wr_data;
        default: begin end
      endcase
    end
  end

  pts_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .item (item),
    .link (link),
    .take (take)
  );

  pts_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .link   (link),
    .take   (take),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

@@ rtl/pts_checker.sv @@
// port-level checks for the photon transport heating engine and their binding
`default_nettype none
module pts_checker import pts_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 full,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire out_item_t            result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_photon_no_heat: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.result_kind) |->
      (result.heat_value == '0 && result.heat_square_value == '0))
    else $error("photon result carries heat data");

  a_photon_count: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.result_kind) |-> (result.photons_finished != '0))
    else $error("photon result with zero finished count");

endmodule

bind photon_transport_shell_heating_unit pts_checker u_pts_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the photon transport shell heating engine: random draws and shell reads
`default_nettype none
module tb_top import pts_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE = 600;

  class heat_scoreboard;
    bit [15:0] albedo;
    bit [31:0] spfp, wthr, sthr, target;
    phase_e    ph;
    bit [31:0] px, py, pz, du, dv, dw, wgt, xi_held, count;
    bit [63:0] heat [SHELL_COUNT];
    bit [63:0] heat_sq [SHELL_COUNT];
    out_item_t pending_q [$];
    int        errors;

    function new();
      albedo = ALBEDO_RESET;
      spfp   = SPFP_RESET;
      wthr   = WTHR_RESET;
      sthr   = STHR_RESET;
      target = TARGET_RESET;
      ph = PH_MOVE;
      xi_held = 0;
      count = 0;
      errors = 0;
      relaunch();
      for (int i = 0; i < SHELL_COUNT; i++) begin
        heat[i] = 0;
        heat_sq[i] = 0;
      end
    endfunction

    function void relaunch();
      px = 0; py = 0; pz = 0;
      du = 0; dv = 0; dw = ONE_Q30;
      wgt = ONE_Q31;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [31:0] val);
      case (idx)
        REG_ALBEDO: albedo = val[15:0];
        REG_SPFP:   spfp = val;
        REG_WTHR:   wthr = val;
        REG_STHR:   sthr = val;
        REG_TARGET: target = val;
        default: ;
      endcase
    endfunction

    function bit [63:0] root64(bit [63:0] n_in);
      bit [63:0] n, res, b;
      n = n_in;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function bit [31:0] step_len(bit [31:0] r);
      int k;
      bit [63:0] m, frac, nl;
      if (r == 0) return 32'hFFFF_FFFF;
      k = 31;
      while (!r[k]) k--;
      m = {32'b0, r} << (31 - k);
      frac = 0;
      for (int i = 1; i <= 24; i++) begin
        m = (m * m) >> 31;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | (64'd1 << (24 - i));
          m = m >> 1;
        end
      end
      nl = (64'd32 << 24) - ((64'(k) << 24) | frac);
      return 32'((nl * 64'(LN2_Q32) + (64'd1 << 39)) >> 40);
    endfunction

    function bit [63:0] mag32(bit [31:0] v);
      bit [31:0] a;
      a = v[31] ? (~v + 32'd1) : v;
      return 64'(a);
    endfunction

    function bit [31:0] move_axis(bit [31:0] p, bit [31:0] d, bit [31:0] t);
      bit [63:0] delta;
      longint np, ps;
      delta = (64'(t) * mag32(d)) >> 30;
      ps = $signed(p);
      np = d[31] ? ps - longint'(delta) : ps + longint'(delta);
      if (np > 64'sd2147483647) np = 64'sd2147483647;
      if (np < -64'sd2147483648) np = -64'sd2147483648;
      return np[31:0];
    endfunction

    function bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function bit [31:0] signed_dir(bit neg, bit [63:0] mag);
      return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function void move_photon(bit [31:0] r);
      bit [31:0] t;
      bit [63:0] rad, sh, dep, dsq;
      t = step_len(r);
      px = move_axis(px, du, t);
      py = move_axis(py, dv, t);
      pz = move_axis(pz, dw, t);
      rad = root64(mag32(px) * mag32(px) + mag32(py) * mag32(py) + mag32(pz) * mag32(pz));
      sh = (rad * 64'(spfp)) >> 32;
      if (sh > SHELL_COUNT - 1) sh = SHELL_COUNT - 1;
      dep = (64'(wgt) * (64'd65536 - 64'(albedo))) >> 15;
      dsq = (dep >= 64'h1_0000_0000) ? 64'h1_0000_0000 : ((dep * dep) >> 32);
      heat[sh] = sat_add(heat[sh], dep);
      heat_sq[sh] = sat_add(heat_sq[sh], dsq);
      wgt = 32'((64'(wgt) * 64'(albedo)) >> 16);
      ph = PH_XI1;
    endfunction

    function void turn_photon(bit [31:0] r);
      longint x1, x2;
      bit [63:0] m1, m2, s, root;
      x1 = longint'(xi_held >> 1) - 64'sd1073741824;
      x2 = longint'(r >> 1) - 64'sd1073741824;
      m1 = (x1 < 0) ? -x1 : x1;
      m2 = (x2 < 0) ? -x2 : x2;
      s = m1 * m1 + m2 * m2;
      if (s == 0 || s > (64'd1 << 60)) begin
        ph = PH_XI1;
        return;
      end
      du = 32'((s >> 29) - 64'd1073741824);
      root = root64((64'd1 << 60) - s);
      dv = signed_dir(x1 < 0, (m1 * root) >> 29);
      dw = signed_dir(x2 < 0, (m2 * root) >> 29);
      ph = ((64'(wgt) * 2) < 64'(wthr)) ? PH_ROUL : PH_MOVE;
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      bit [63:0] w;
      e = '0;
      if (it.kind == OP_READ) begin
        e.result_kind = OP_READ;
        e.photons_finished = count;
        e.run_done = (count >= target);
        e.heat_value = heat[it.shell_index];
        e.heat_square_value = heat_sq[it.shell_index];
        pending_q.push_back(e);
        return;
      end
      if (count >= target) return;
      case (ph)
        PH_MOVE: move_photon(it.rand_value);
        PH_XI1: begin
          xi_held = it.rand_value;
          ph = PH_XI2;
        end
        PH_XI2: turn_photon(it.rand_value);
        default: begin
          if (it.rand_value > sthr) begin
            if (count != 32'hFFFF_FFFF) count++;
            relaunch();
            ph = PH_MOVE;
            e.result_kind = OP_DRAW;
            e.photons_finished = count;
            e.run_done = (count >= target);
            pending_q.push_back(e);
          end else begin
            w = 64'(wgt) * 10;
            wgt = (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
            ph = PH_MOVE;
          end
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.result_kind !== e.result_kind) begin
        $display("%0t: result_kind exp %h got %h", $time, e.result_kind, got.result_kind);
        errors++;
      end
      if (got.photons_finished !== e.photons_finished) begin
        $display("%0t: photons_finished exp %h got %h", $time, e.photons_finished,
                 got.photons_finished);
        errors++;
      end
      if (got.run_done !== e.run_done) begin
        $display("%0t: run_done exp %h got %h", $time, e.run_done, got.run_done);
        errors++;
      end
      if (got.heat_value !== e.heat_value) begin
        $display("%0t: heat_value exp %h got %h", $time, e.heat_value, got.heat_value);
        errors++;
      end
      if (got.heat_square_value !== e.heat_square_value) begin
        $display("%0t: heat_square_value exp %h got %h", $time, e.heat_square_value,
                 got.heat_square_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst, push, full, empty, pop, wr_en;
  in_item_t item;
  out_item_t result;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [31:0] wr_data;

  heat_scoreboard sb;
  bit no_idle = 0;
  bit hold_req = 0;
  int cycles = 0;

  photon_transport_shell_heating_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(bit k, bit [31:0] r, bit [6:0] idx);
    int gap;
    in_item_t it;
    it.kind = k;
    it.rand_value = r;
    it.shell_index = idx;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    push <= 1'b1;
    @(negedge clk);
    while (full) @(negedge clk);
    sb.note_input(it);
    @(posedge clk);
  endtask

  task automatic take_results();
    int gap;
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (hold_req) begin
        gap = 400;
        hold_req = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
      while (empty) @(negedge clk);
      sb.check_result(result);
      @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(bit [15:0] a, bit [31:0] s, bit [31:0] wt, bit [31:0] st,
                           bit [31:0] tg);
    write_reg(REG_ALBEDO, {16'b0, a});
    write_reg(REG_SPFP, s);
    write_reg(REG_WTHR, wt);
    write_reg(REG_STHR, st);
    write_reg(REG_TARGET, tg);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [31:0] pick_draw();
    case ($urandom_range(0, 11))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000 | $urandom_range(0, 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) send_item(OP_READ, $urandom, $urandom_range(0, 127));
      else send_item(OP_DRAW, pick_draw(), $urandom_range(0, 127));
    end
  endtask

  initial begin
    sb = new();
    rst <= 1'b1;
    push <= 1'b0;
    pop <= 1'b0;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    item <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      take_results();
    join_none

    // reset settings: saturated step, both rejections, an accepted pair
    send_item(OP_READ, 32'h0, 7'd0);
    send_item(OP_DRAW, 32'h0, 7'd0);
    send_item(OP_READ, 32'h0, 7'd127);
    send_item(OP_DRAW, 32'h8000_0000, 7'd0);
    send_item(OP_DRAW, 32'h8000_0001, 7'd0);
    send_item(OP_DRAW, 32'h0, 7'd0);
    send_item(OP_DRAW, 32'h0, 7'd0);
    send_item(OP_DRAW, 32'hFFFF_FFFF, 7'd0);
    send_item(OP_DRAW, 32'h8000_0000, 7'd0);
    send_item(OP_DRAW, 32'h0000_0001, 7'h7F);
    send_item(OP_READ, 32'hFFFF_FFFF, 7'd127);
    drain();

    // full deposit, roulette survive then end, run done
    configure(16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd2);
    send_item(OP_DRAW, 32'h0000_0001, 7'd0);
    send_item(OP_DRAW, 32'h8000_0000, 7'd0);
    send_item(OP_DRAW, 32'hC000_0000, 7'd0);
    send_item(OP_DRAW, 32'h0, 7'd0);
    send_item(OP_DRAW, 32'hFFFF_FFFF, 7'd0);
    send_item(OP_DRAW, 32'h4000_0000, 7'd0);
    send_item(OP_DRAW, 32'hA000_0000, 7'd0);
    send_item(OP_DRAW, 32'h0000_0005, 7'd0);
    send_item(OP_DRAW, 32'h1234_5678, 7'd0);
    send_item(OP_DRAW, 32'h9000_0000, 7'd0);
    send_item(OP_DRAW, 32'h7000_0000, 7'd0);
    send_item(OP_DRAW, 32'hFFFF_FFFF, 7'd0);
    send_item(OP_DRAW, 32'h5555_5555, 7'd0);
    send_item(OP_READ, 32'h0, 7'd127);
    drain();

    configure(16'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    random_items(120);
    drain();

    configure(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1);
    random_items(40);
    drain();

    hold_req = 1;
    configure($urandom_range(0, 20000), $urandom, 32'hFFFF_FFFF, $urandom,
              sb.count + $urandom_range(5, 30));
    random_items(140);
    drain();

    no_idle = 1;
    configure($urandom_range(0, 40000), $urandom_range(0, 2000000), $urandom | 32'h8000_0000,
              $urandom, sb.count + $urandom_range(3, 40));
    random_items(120);
    drain();
    no_idle = 0;

    repeat (2) begin
      configure($urandom_range(0, 65535), $urandom, $urandom | 32'h4000_0000, $urandom,
                sb.count + $urandom_range(3, 40));
      random_items(120);
      drain();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
